/* sv/crr_pkg.sv */
// crr_pkg: shared types and constants for the chained range remap block.
// No dependencies.
`timescale 1ns / 1ps
package crr_pkg;
  localparam int unsigned Stages       = 8;
  localparam int unsigned MapEntries   = 32;
  localparam int unsigned MemberRanges = 32;
  localparam int unsigned StageW = (Stages > 1) ? $clog2(Stages) : 1;
  localparam int unsigned EntryW = (MapEntries > 1) ? $clog2(MapEntries) : 1;
  localparam int unsigned MemW   = (MemberRanges > 1) ? $clog2(MemberRanges) : 1;
  localparam int unsigned CntW   = $clog2(Stages + 1);

  typedef enum logic [1:0] {
    REQ_MAP    = 2'd0,
    REQ_MEMBER = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef struct packed {
    logic [31:0] match_base;
    logic [31:0] output_base;
    logic [31:0] span_length;
  } map_entry_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } member_t;

  // write request broadcast from the top level to the tables
  typedef struct packed {
    logic        map_we;
    logic        mem_we;
    logic [2:0]  stage;
    logic [4:0]  index;
    logic [31:0] base;
    logic [31:0] obase;
    logic [31:0] len;
  } wr_t;

  // pipeline payload between stages
  typedef struct packed {
    logic            valid;
    logic [CntW-1:0] left;
    logic [31:0]     value;
  } pl_t;

  function automatic logic in_span(logic [31:0] v, logic [31:0] b, logic [31:0] l);
    logic [32:0] e;
    e = {1'b0, b} + {1'b0, l};
    return (v >= b) && ({1'b0, v} < e);
  endfunction
endpackage

/* sv/crr_stage.sv */
// crr_stage: one remap level with its own entry table and parallel compare.
// Depends on crr_pkg.
`timescale 1ns / 1ps
module crr_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [2:0]        sid_i,
  input  crr_pkg::wr_t      wr_i,
  input  crr_pkg::pl_t      pl_i,
  output crr_pkg::pl_t      pl_o
);
  import crr_pkg::*;
  map_entry_t tbl_q [MapEntries];
  logic [MapEntries-1:0] hit;
  pl_t pl_d;
  logic            valid_q;
  logic [CntW-1:0] left_q;
  logic [31:0]     value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MapEntries; i++) tbl_q[i] <= '0;
    end else if (wr_i.map_we && wr_i.stage == sid_i &&
                 {27'd0, wr_i.index} < 32'(MapEntries)) begin
      tbl_q[wr_i.index[EntryW-1:0]] <= '{wr_i.base, wr_i.obase, wr_i.len};
    end
  end

  always_comb begin
    for (int i = 0; i < MapEntries; i++)
      hit[i] = in_span(pl_i.value, tbl_q[i].match_base, tbl_q[i].span_length);
    pl_d = pl_i;
    if (pl_i.left != '0) begin
      pl_d.left = pl_i.left - 1'b1;
      for (int i = MapEntries - 1; i >= 0; i--)
        if (hit[i])
          pl_d.value = tbl_q[i].output_base + (pl_i.value - tbl_q[i].match_base);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= pl_d.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      left_q  <= pl_d.left;
      value_q <= pl_d.value;
    end
  end
  assign pl_o = '{valid_q, left_q, value_q};
endmodule

/* sv/crr_member.sv */
// crr_member: membership range table and final membership compare stage.
// Depends on crr_pkg.
`timescale 1ns / 1ps
module crr_member (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  crr_pkg::wr_t wr_i,
  input  crr_pkg::pl_t pl_i,
  output logic         valid_o,
  output logic [31:0]  value_o,
  output logic         member_o
);
  import crr_pkg::*;
  member_t tbl_q [MemberRanges];
  logic hit_d, valid_q, hit_q;
  logic [31:0] value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MemberRanges; i++) tbl_q[i] <= '0;
    end else if (wr_i.mem_we && {27'd0, wr_i.index} < 32'(MemberRanges)) begin
      tbl_q[wr_i.index[MemW-1:0]] <= '{wr_i.base, wr_i.len};
    end
  end

  always_comb begin
    hit_d = 1'b0;
    for (int i = 0; i < MemberRanges; i++)
      hit_d |= in_span(pl_i.value, tbl_q[i].start, tbl_q[i].length);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= pl_i.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= pl_i.value;
      hit_q   <= hit_d;
    end
  end
  assign valid_o  = valid_q;
  assign value_o  = value_q;
  assign member_o = hit_q;
endmodule

/* sv/chained_range_remap.sv */
// chained_range_remap: top level, a register stage per remap level plus a
// membership stage. Depends on crr_pkg, crr_stage, crr_member.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries items: writes of a map entry or a membership range, and
//   lookups. Only lookups give a result on m_axis; writes and req_type 3
//   vanish. A write takes effect at its accept edge; it is held off
//   (s_axis_tready low) while any lookup is still in the remap stages, so
//   every lookup sees exactly the writes accepted before it.
//   Throughput: one lookup per cycle while the output is not stalled; a write
//   behind lookups waits for the remap stages to empty. Depth: Stages + 1
//   register levels, the first loaded at the accept edge: one level per remap
//   stage (parallel entry compare) and one for the membership compare.
//   Stall: the whole pipe holds when the output register is full and not
//   taken; a bubble in the output register lets the pipe advance. Nothing
//   is lost or repeated.
//   cfg_we_i writes stages_used (values above Stages act as Stages); write
//   it only while no lookup is in flight.
//   Reset: tables cleared (all entries inactive), stages_used = 7, pipe empty.
module chained_range_remap (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [3:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type[1:0] stage_select[4:2] entry_index[9:5] match_base[41:10]
  // output_base[73:42] span_length[105:74] lookup_value[137:106], pad to 144
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mapped_value[31:0] in_member_range[32], pad to 40
  output logic [39:0]  m_axis_tdata
);
  import crr_pkg::*;

  logic [3:0] stages_q;
  logic en, acc, busy, wr_req;
  req_e req;
  wr_t wr;
  pl_t pl_in;
  pl_t pl [Stages+1];
  logic [CntW-1:0] n;
  logic [31:0] val;
  logic mem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) stages_q <= 4'd7;
    else if (cfg_we_i) stages_q <= cfg_wdata_i;
  end

  // any lookup still walking the remap stages
  always_comb begin
    busy = 1'b0;
    for (int g = 1; g <= Stages; g++) busy |= pl[g].valid;
  end

  assign en     = !m_axis_tvalid || m_axis_tready;
  assign req    = req_e'(s_axis_tdata[1:0]);
  assign wr_req = (req == REQ_MAP) || (req == REQ_MEMBER);
  // a write waits until no earlier lookup can still read the tables
  assign s_axis_tready = en && !(wr_req && busy);
  assign acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    wr.map_we = acc && req == REQ_MAP;
    wr.mem_we = acc && req == REQ_MEMBER;
    wr.stage  = s_axis_tdata[4:2];
    wr.index  = s_axis_tdata[9:5];
    wr.base   = s_axis_tdata[41:10];
    wr.obase  = s_axis_tdata[73:42];
    wr.len    = s_axis_tdata[105:74];
    // clamp stage count
    if (32'(stages_q) > 32'(Stages)) n = CntW'(Stages);
    else n = CntW'(stages_q);
    pl_in.valid = acc && req == REQ_LOOKUP;
    pl_in.left  = n;
    pl_in.value = s_axis_tdata[137:106];
  end

  assign pl[0] = pl_in;

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    crr_stage u_stage (
      .clk_i, .rst_ni, .en_i(en), .sid_i(3'(g)), .wr_i(wr),
      .pl_i(pl[g]), .pl_o(pl[g+1])
    );
  end

  crr_member u_member (
    .clk_i, .rst_ni, .en_i(en), .wr_i(wr), .pl_i(pl[Stages]),
    .valid_o(m_axis_tvalid), .value_o(val), .member_o(mem)
  );

  assign m_axis_tdata = {7'd0, mem, val};
endmodule
